// ===== design/chm_pkg.sv =====
// Shared types and constants for the chained hash map engine.
// No dependencies; chm_front, chm_back and the core module import this package.
package chm_pkg;

    localparam int KEY_W           = 63;
    localparam int VAL_W           = 64;
    localparam int CNT_OUT_W       = 11;
    localparam int CFG_W           = 9;
    localparam int DEF_MAX_BUCKETS = 256;
    localparam int DEF_NODE_POOL   = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    // The remainder unit retires this many key bits per cycle.
    localparam int REM_BITS  = 8;
    localparam int REM_STEPS = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_SET    = 2'd2,
        ACT_ERASE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_HEAD,
        BS_HWAIT,
        BS_RD,
        BS_CMP,
        BS_ARD,
        BS_ALLOC,
        BS_LINK,
        BS_UNLINK,
        BS_FREE,
        BS_RESP
    } t_bstate;

endpackage

// ===== design/chm_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
// Depends on nothing; used by the front, back and top-level modules.
interface chm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [62:0] key;
    logic [63:0] value;
    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

interface chm_out_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [63:0] value_out;
    logic [10:0] entry_count;
    modport source (output valid, success, value_out, entry_count, input ready);
    modport sink   (input valid, success, value_out, entry_count, output ready);
endinterface

// ===== design/chm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module chm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/chm_fifo.sv =====
// Two-entry queue between the classifying front end and the table sequencer.
// Depends on nothing.
module chm_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== design/chm_front.sv =====
// Front end: accepts request beats, holds the bucket count register and
// works out the bucket index with an eight-bits-per-cycle remainder unit.
// Depends on chm_pkg and chm_if.
module chm_front
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int DIV_W = $clog2(MAX_BUCKETS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    chm_in_if.sink           i_in,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output t_cmd             o_push_cmd,
    output logic [BKT_W-1:0] o_push_bkt
);
    localparam int STEP_W = $clog2(REM_STEPS);
    localparam int SHR_W  = REM_BITS * REM_STEPS;

    logic [CFG_W-1:0]  r_bucket_count;
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    t_cmd              r_cmd;
    logic [SHR_W-1:0]  r_shift;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  n_rem;
    logic [DIV_W-1:0]  eff_div;
    logic              accept;

    // Zero selects one bucket; anything above the table size saturates.
    always_comb begin
        logic [31:0] cfg32;
        cfg32 = 32'(r_bucket_count);
        if (cfg32 == 32'd0) begin
            eff_div = DIV_W'(1);
        end else if (cfg32 > 32'(MAX_BUCKETS)) begin
            eff_div = DIV_W'(MAX_BUCKETS);
        end else begin
            eff_div = cfg32[DIV_W-1:0];
        end
    end

    // Restoring remainder over one byte of the key, most significant first.
    always_comb begin
        logic [DIV_W:0]     t;
        logic [DIV_W-1:0]   rem;
        logic [REM_BITS-1:0] byte_in;
        rem     = r_rem;
        byte_in = r_shift[SHR_W-1 -: REM_BITS];
        for (int j = REM_BITS - 1; j >= 0; j--) begin
            t = {rem, byte_in[j]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem = t[DIV_W-1:0];
        end
        n_rem = rem;
    end

    assign i_in.ready   = !r_busy;
    assign accept       = i_in.valid && !r_busy;
    assign o_push_valid = r_done;
    assign o_push_cmd   = r_cmd;
    assign o_push_bkt   = BKT_W'(r_rem);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.action <= t_action'(i_in.action);
            r_cmd.key    <= i_in.key;
            r_cmd.value  <= i_in.value;
            r_shift      <= SHR_W'(i_in.key);
            r_div        <= eff_div;
            r_rem        <= '0;
        end else if (r_busy && !r_done) begin
            r_shift <= r_shift << REM_BITS;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_RESET;
            r_busy         <= 1'b0;
            r_done         <= 1'b0;
            r_step         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy && !r_done) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(REM_STEPS - 1)) begin
                    r_done <= 1'b1;
                end
            end else if (r_done && i_push_ready) begin
                r_done <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== design/chm_back.sv =====
// Back end: walks bucket chains and carries out insert, get, set and erase
// on the node pool, then registers one result beat. Depends on chm_pkg,
// chm_if and chm_ram.
module chm_back
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int NODE_POOL   = DEF_NODE_POOL,
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int LINK_W = $clog2(NODE_POOL + 1),
    localparam int IDX_W  = $clog2(NODE_POOL)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  t_cmd             i_q_cmd,
    input  logic [BKT_W-1:0] i_q_bkt,
    chm_out_if.source        o_out
);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_POOL);

    t_bstate r_state, n_state;

    t_cmd               r_cmd;
    logic [BKT_W-1:0]   r_bkt;
    logic [MAX_BUCKETS-1:0] r_head_vld;
    logic               r_hvld;
    logic [LINK_W-1:0]  r_cur;
    logic [LINK_W-1:0]  r_prev;
    logic [LINK_W-1:0]  r_hit_next;
    logic [LINK_W-1:0]  r_new;
    logic               r_from_list;
    logic [LINK_W-1:0]  r_free_head;
    logic [LINK_W-1:0]  r_fresh;
    logic [LINK_W-1:0]  r_count;
    logic               r_ok;
    logic [VAL_W-1:0]   r_vout;
    logic               r_out_valid;
    logic               r_out_success;
    logic [VAL_W-1:0]   r_out_value;
    logic [CNT_OUT_W-1:0] r_out_count;

    // RAM ports
    logic               head_we, head_re;
    logic [BKT_W-1:0]   head_waddr;
    logic [LINK_W-1:0]  head_wdata, head_rdata;
    logic               key_we, ent_re;
    logic [IDX_W-1:0]   ent_raddr;
    logic [KEY_W-1:0]   key_rdata;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [VAL_W-1:0]   val_wdata, val_rdata;
    logic               nxt_we, nxt_re;
    logic [IDX_W-1:0]   nxt_waddr, nxt_raddr;
    logic [LINK_W-1:0]  nxt_wdata, nxt_rdata;

    logic [LINK_W-1:0]  hw_cur;
    logic               key_hit;
    logic               walk_miss;
    logic               out_free;
    t_bstate            miss_state;

    chm_ram #(.W(LINK_W), .DEPTH(MAX_BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(head_re), .i_raddr(r_bkt), .o_rdata(head_rdata)
    );
    chm_ram #(.W(KEY_W), .DEPTH(NODE_POOL)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_new[IDX_W-1:0]), .i_wdata(r_cmd.key),
        .i_re(ent_re), .i_raddr(ent_raddr), .o_rdata(key_rdata)
    );
    chm_ram #(.W(VAL_W), .DEPTH(NODE_POOL)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_re(ent_re), .i_raddr(ent_raddr), .o_rdata(val_rdata)
    );
    chm_ram #(.W(LINK_W), .DEPTH(NODE_POOL)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_re(nxt_re), .i_raddr(nxt_raddr), .o_rdata(nxt_rdata)
    );

    assign hw_cur   = r_hvld ? head_rdata : NIL;
    assign key_hit  = (key_rdata == r_cmd.key);
    assign out_free = !r_out_valid || o_out.ready;
    assign walk_miss = ((r_state == BS_HWAIT) && (hw_cur >= NIL))
                    || ((r_state == BS_CMP) && !key_hit && (nxt_rdata >= NIL));

    // An insert that misses takes a recycled entry first, then a fresh one.
    always_comb begin
        miss_state = BS_RESP;
        if (r_cmd.action == ACT_INSERT) begin
            if (r_free_head != NIL) begin
                miss_state = BS_ARD;
            end else if (r_fresh != NIL) begin
                miss_state = BS_ALLOC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_ready  = 1'b0;
        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = r_bkt;
        head_wdata = r_new;
        key_we     = 1'b0;
        ent_re     = 1'b0;
        ent_raddr  = r_cur[IDX_W-1:0];
        val_we     = 1'b0;
        val_waddr  = r_cur[IDX_W-1:0];
        val_wdata  = r_cmd.value;
        nxt_we     = 1'b0;
        nxt_re     = 1'b0;
        nxt_waddr  = r_new[IDX_W-1:0];
        nxt_wdata  = NIL;
        nxt_raddr  = r_cur[IDX_W-1:0];
        case (r_state)
            BS_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_state = BS_HEAD;
                end
            end
            BS_HEAD: begin
                head_re = 1'b1;
                n_state = BS_HWAIT;
            end
            BS_HWAIT: begin
                n_state = walk_miss ? miss_state : BS_RD;
            end
            BS_RD: begin
                ent_re  = 1'b1;
                nxt_re  = 1'b1;
                n_state = BS_CMP;
            end
            BS_CMP: begin
                if (key_hit) begin
                    case (r_cmd.action)
                        ACT_ERASE: n_state = BS_UNLINK;
                        ACT_SET: begin
                            val_we  = 1'b1;
                            n_state = BS_RESP;
                        end
                        default: n_state = BS_RESP;
                    endcase
                end else if (walk_miss) begin
                    n_state = miss_state;
                end else begin
                    n_state = BS_RD;
                end
            end
            BS_ARD: begin
                nxt_re    = 1'b1;
                nxt_raddr = r_free_head[IDX_W-1:0];
                n_state   = BS_ALLOC;
            end
            BS_ALLOC: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                val_waddr = r_new[IDX_W-1:0];
                nxt_we    = 1'b1;
                n_state   = BS_LINK;
            end
            BS_LINK: begin
                if (r_prev != NIL) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_prev[IDX_W-1:0];
                    nxt_wdata = r_new;
                end else begin
                    head_we = 1'b1;
                end
                n_state = BS_RESP;
            end
            BS_UNLINK: begin
                if (r_prev != NIL) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_prev[IDX_W-1:0];
                    nxt_wdata = r_hit_next;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = r_hit_next;
                end
                n_state = BS_FREE;
            end
            BS_FREE: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_cur[IDX_W-1:0];
                nxt_wdata = r_free_head;
                n_state   = BS_RESP;
            end
            BS_RESP: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    r_cmd  <= i_q_cmd;
                    r_bkt  <= i_q_bkt;
                    r_ok   <= 1'b0;
                    r_vout <= '0;
                end
            end
            BS_HEAD: r_hvld <= r_head_vld[r_bkt];
            BS_HWAIT: begin
                r_prev <= NIL;
                r_cur  <= hw_cur;
            end
            BS_CMP: begin
                if (key_hit) begin
                    r_hit_next <= nxt_rdata;
                    if (r_cmd.action == ACT_GET) begin
                        r_ok   <= 1'b1;
                        r_vout <= val_rdata;
                    end else if (r_cmd.action == ACT_SET) begin
                        r_ok <= 1'b1;
                    end
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= nxt_rdata;
                end
            end
            BS_LINK: r_ok <= 1'b1;
            BS_FREE: r_ok <= 1'b1;
            default: ;
        endcase
        if (walk_miss) begin
            r_from_list <= (r_free_head != NIL);
            r_new       <= (r_free_head != NIL) ? r_free_head : r_fresh;
        end
        if (r_state == BS_RESP && out_free) begin
            r_out_success <= r_ok;
            r_out_value   <= r_vout;
            r_out_count   <= CNT_OUT_W'(32'(r_count));
        end
    end

    // Control registers: pool bookkeeping, head valid bits, result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld  <= '0;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (head_we) begin
                r_head_vld[r_bkt] <= 1'b1;
            end
            if (r_state == BS_ALLOC) begin
                r_count <= r_count + LINK_W'(1);
                if (r_from_list) begin
                    r_free_head <= nxt_rdata;
                end else begin
                    r_fresh <= r_fresh + LINK_W'(1);
                end
            end
            if (r_state == BS_FREE) begin
                r_free_head <= r_cur;
                if (r_count != '0) begin
                    r_count <= r_count - LINK_W'(1);
                end
            end
            if (r_state == BS_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.success     = r_out_success;
    assign o_out.value_out   = r_out_value;
    assign o_out.entry_count = r_out_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count exceeds the pool size");
    a_free_recycled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head != NIL) |-> (r_free_head < r_fresh))
        else $error("free list head names an entry never handed out");
    a_alloc_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_ALLOC) |-> (r_new < NIL))
        else $error("allocation outside the node pool");
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_ALLOC && !r_from_list) |=> (r_fresh <= NIL))
        else $error("fresh pointer ran past the pool");
`endif
endmodule

// ===== design/chained_hash_map_engine_core.sv =====
// The front end accepts a request, runs 8 remainder steps and queues it; the back
// end reads the bucket head, reads and compares each chain entry it visits, makes any
// update and registers one result beat. The front end takes no new request until the
// last one is in the queue, and the back end takes one from the queue only when idle.
// Reset is synchronous and active low; bucket heads clear at once through
// valid bits, so items are accepted straight after reset.
module chained_hash_map_engine_core
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int NODE_POOL   = DEF_NODE_POOL
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    chm_in_if.sink           i_in,
    chm_out_if.source        o_out
);
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW    = $bits(t_cmd) + BKT_W;

    logic             f_valid, f_ready;
    t_cmd             f_cmd;
    logic [BKT_W-1:0] f_bkt;
    logic             q_valid, q_ready;
    logic [QW-1:0]    q_data;
    t_cmd             q_cmd;
    logic [BKT_W-1:0] q_bkt;

    chm_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(i_in),
        .o_push_valid(f_valid), .i_push_ready(f_ready),
        .o_push_cmd(f_cmd), .o_push_bkt(f_bkt)
    );

    chm_fifo #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(f_valid), .o_push_ready(f_ready), .i_push_data({f_cmd, f_bkt}),
        .o_pop_valid(q_valid), .i_pop_ready(q_ready), .o_pop_data(q_data)
    );

    assign q_cmd = q_data[QW-1:BKT_W];
    assign q_bkt = q_data[BKT_W-1:0];

    chm_back #(.MAX_BUCKETS(MAX_BUCKETS), .NODE_POOL(NODE_POOL)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_cmd(q_cmd), .i_q_bkt(q_bkt),
        .o_out(o_out)
    );
endmodule
